// File: sv/doubly_linked_list_engine_assert.svh
// Assertion macros for the linked list engine.
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
// Implication checked every cycle outside reset.
`define DLL_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DLL_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: sv/dll_pkg.sv
// Shared types and codes of the linked list engine.
package dll_pkg;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_INSERT_AT  = 3'd4;
  localparam logic [2:0] CMD_REMOVE_AT  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    OP_NONE, OP_PUSH_BACK, OP_PUSH_FRONT, OP_POP_FRONT, OP_POP_BACK, OP_INSERT_MID,
    OP_REMOVE_MID
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_WALK, BK_LINK, BK_DONE
  } bk_state_t;
endpackage

// File: sv/dll_front.sv
// Front end: accepts commands, classifies them and holds them in a one-entry queue.
module dll_front import dll_pkg::*; #(
  parameter int CW = 6,
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    command,
  input  logic [5:0]    position,
  input  logic [31:0]   value,
  input  logic [CW-1:0] cur_count,
  output logic          q_valid,
  output op_t           q_op,
  output logic [5:0]    q_pos,
  output logic [31:0]   q_val,
  output logic [1:0]    q_status,
  input  logic          q_take
);
  logic        held;
  op_t         op_c;
  logic [1:0]  st_c;
  logic [CW:0] cnt1;
  logic        full_c;

  // Count changes only in the back end, so one command is in flight at a time.
  assign busy = held;
  assign q_valid = held;
  assign cnt1 = {1'b0, cur_count} + 1'b1;
  assign full_c = ({1'b0, cur_count} >= (CW+1)'(CAPACITY));

  // Classify a command against the current count.
  always_comb begin
    op_c = OP_NONE;
    st_c = ST_OK;
    unique case (command)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full_c) st_c = ST_FULL;
        else op_c = (command == CMD_PUSH_BACK) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (cur_count == '0) st_c = ST_EMPTY;
        else op_c = (command == CMD_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
      end
      CMD_INSERT_AT: begin
        if (position == '0 || (CW+1)'(position) > cnt1) st_c = ST_BADPOS;
        else if (full_c) st_c = ST_FULL;
        else if ((CW+1)'(position) == cnt1) op_c = OP_PUSH_BACK;
        else if (position == 6'd1) op_c = OP_PUSH_FRONT;
        else op_c = OP_INSERT_MID;
      end
      CMD_REMOVE_AT: begin
        if (cur_count == '0) st_c = ST_EMPTY;
        else if (position == '0 || (CW+1)'(position) > (CW+1)'(cur_count)) st_c = ST_BADPOS;
        else if (position == 6'd1) op_c = OP_POP_FRONT;
        else if ((CW+1)'(position) == (CW+1)'(cur_count)) op_c = OP_POP_BACK;
        else op_c = OP_REMOVE_MID;
      end
      default: op_c = OP_NONE;
    endcase
  end

  // Queue entry and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (start && !busy) begin
      held <= 1'b1;
    end else if (q_take) begin
      held <= 1'b0;
    end
    if (start && !busy) begin
      q_op <= op_c; q_pos <= position; q_val <= value; q_status <= st_c;
    end
  end

  `include "doubly_linked_list_engine_assert.svh"
  `DLL_ASSERT_IMP(a_busy_held, q_valid, busy)
  `DLL_ASSERT_NXT(a_accept_fills, start && !busy, q_valid)
  `DLL_ASSERT_NXT(a_take_clears, q_take, !q_valid)
  `DLL_ASSERT_IMP(a_take_valid, q_take, q_valid)
endmodule

// File: sv/dll_back.sv
// Back end: node memory, free map and link walker.
module dll_back import dll_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int DATA_WIDTH = 32,
  parameter int IW = 5,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  op_t           q_op,
  input  logic [5:0]    q_pos,
  input  logic [31:0]   q_val,
  input  logic [1:0]    q_status,
  output logic          q_take,
  output logic [CW-1:0] cur_count,
  output logic          done,
  output logic [31:0]   removed_value,
  output logic [1:0]    status,
  output logic [5:0]    element_count
);
  logic [DATA_WIDTH-1:0] ndata [CAPACITY];
  logic [IW-1:0] nxt [CAPACITY];
  logic [IW-1:0] prv [CAPACITY];
  logic [CAPACITY-1:0] free_map;
  logic [IW-1:0] head, tail, cur, rd_next, rd_prev, newn;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [CW-1:0] count;
  logic [5:0] steps;
  bk_state_t state, state_next;
  logic [31:0] rem_r;
  logic [1:0] st_r;

  assign cur_count = count;

  // Lowest free node.
  always_comb begin
    newn = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) if (free_map[i]) newn = IW'(i);
  end

  always_comb begin
    state_next = state;
    q_take = 1'b0;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_READ;
      BK_READ: begin
        if (q_op == OP_INSERT_MID || q_op == OP_REMOVE_MID) state_next = BK_WALK;
        else state_next = BK_DONE;
      end
      BK_WALK: if (steps == 6'd0) state_next = BK_LINK;
      BK_LINK: state_next = BK_DONE;
      BK_DONE: begin
        q_take = 1'b1;
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Registered memory reads of the current node.
  always_ff @(posedge clk) begin
    rd_data <= ndata[cur];
    rd_next <= nxt[cur];
    rd_prev <= prv[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      free_map <= '1;
      head <= '0;
      tail <= '0;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        BK_IDLE: begin
          st_r <= q_status;
          rem_r <= '0;
          unique case (q_op)
            OP_POP_FRONT: cur <= head;
            OP_POP_BACK:  cur <= tail;
            default:      cur <= head;
          endcase
          steps <= q_pos - 6'd1;
        end
        BK_READ: begin
          unique case (q_op)
            OP_PUSH_BACK: begin
              free_map[newn] <= 1'b0;
              ndata[newn] <= q_val[DATA_WIDTH-1:0];
              nxt[newn] <= '0;
              prv[newn] <= (count == '0) ? '0 : tail;
              if (count != '0) nxt[tail] <= newn;
              else head <= newn;
              tail <= newn;
              count <= count + 1'b1;
            end
            OP_PUSH_FRONT: begin
              free_map[newn] <= 1'b0;
              ndata[newn] <= q_val[DATA_WIDTH-1:0];
              prv[newn] <= '0;
              nxt[newn] <= (count == '0) ? '0 : head;
              if (count != '0) prv[head] <= newn;
              else tail <= newn;
              head <= newn;
              count <= count + 1'b1;
            end
            OP_POP_FRONT: begin
              free_map[cur] <= 1'b1;
              rem_r <= 32'(ndata[cur]);
              if (count > CW'(1)) head <= nxt[cur];
              count <= count - 1'b1;
            end
            OP_POP_BACK: begin
              free_map[cur] <= 1'b1;
              rem_r <= 32'(ndata[cur]);
              if (count > CW'(1)) tail <= prv[cur];
              count <= count - 1'b1;
            end
            default: ;
          endcase
        end
        BK_WALK: begin
          // Follow one next link per cycle until the target node is reached.
          if (steps != 6'd0) begin
            cur <= nxt[cur];
            steps <= steps - 6'd1;
          end
        end
        BK_LINK: begin
          if (q_op == OP_INSERT_MID) begin
            free_map[newn] <= 1'b0;
            ndata[newn] <= q_val[DATA_WIDTH-1:0];
            nxt[newn] <= cur;
            prv[newn] <= rd_prev;
            nxt[rd_prev] <= newn;
            prv[cur] <= newn;
            count <= count + 1'b1;
          end else begin
            rem_r <= 32'(rd_data);
            nxt[rd_prev] <= rd_next;
            prv[rd_next] <= rd_prev;
            free_map[cur] <= 1'b1;
            count <= count - 1'b1;
          end
        end
        BK_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assign removed_value = rem_r;
  assign status = st_r;
  assign element_count = 6'(count);

  `include "doubly_linked_list_engine_assert.svh"
  `DLL_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(CAPACITY))
  `DLL_ASSERT_NXT(a_take_done, q_take, done)
  `DLL_ASSERT_IMP(a_free_count, 1'b1, $countones(free_map) + count == CAPACITY)
endmodule

// File: sv/doubly_linked_list_engine.sv
// Top level of the doubly linked list engine.
// Push, pop and error results pass through the back-end states idle, read and done.
// Positional insert or remove in the middle also passes through the walk and link states,
// where the link walk reads one node per cycle from the node memory.
// One command is in flight at a time; busy drops as done shows.
// Synchronous reset empties the list and frees every node at once.
module doubly_linked_list_engine import dll_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [5:0]  position,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] removed_value,
  output logic [1:0]  status,
  output logic [5:0]  element_count
);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  logic q_valid, q_take;
  op_t q_op;
  logic [5:0] q_pos;
  logic [31:0] q_val;
  logic [1:0] q_status;
  logic [CW-1:0] cur_count;

  dll_front #(.CW(CW), .CAPACITY(CAPACITY)) u_front (
    .clk, .rst, .start, .busy, .command, .position, .value, .cur_count,
    .q_valid, .q_op, .q_pos, .q_val, .q_status, .q_take
  );

  dll_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH), .IW(IW), .CW(CW)) u_back (
    .clk, .rst, .q_valid, .q_op, .q_pos, .q_val, .q_status, .q_take, .cur_count,
    .done, .removed_value, .status, .element_count
  );
endmodule

// File: sim/doubly_linked_list_engine_test.sv
// Self-checking testbench for the doubly linked list engine.
`timescale 1ns / 1ps

module doubly_linked_list_engine_test;
  import dll_pkg::*;

  localparam int NODES = 32;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 50;

  // Directed row: command, expected result if known.
  typedef struct {
    logic [2:0]  cmd;
    logic [5:0]  pos;
    logic [31:0] val;
    bit          known;
    logic [31:0] exp_removed;
    logic [1:0]  exp_status;
    logic [5:0]  exp_count;
  } directed_row_t;

  typedef struct {
    logic [31:0] removed;
    logic [1:0]  status;
    logic [5:0]  count;
  } list_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  command;
  logic [5:0]  position;
  logic [31:0] value;
  logic        done;
  logic [31:0] removed_value;
  logic [1:0]  status;
  logic [5:0]  element_count;

  // The list contents in order, front first.
  logic [31:0] shadow_list[$];
  list_result_t pending_results[$];
  int mismatch_count;
  int result_count;
  int cycle_count;
  int sender_idle_pct;
  int status_seen[4];

  doubly_linked_list_engine i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .position(position), .value(value), .done(done), .removed_value(removed_value),
    .status(status), .element_count(element_count)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Computes the result of one command and updates the shadow list.
  function automatic list_result_t apply_list_command(logic [2:0] cmd, logic [5:0] pos,
                                                      logic [31:0] val);
    list_result_t r;
    int n;
    n = shadow_list.size();
    r.removed = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (n >= NODES) r.status = ST_FULL;
        else if (cmd == CMD_PUSH_BACK) shadow_list.push_back(val);
        else shadow_list.push_front(val);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (cmd == CMD_POP_FRONT) r.removed = shadow_list.pop_front();
        else r.removed = shadow_list.pop_back();
      end
      CMD_INSERT_AT: begin
        if (pos == 0 || pos > n + 1) r.status = ST_BADPOS;
        else if (n >= NODES) r.status = ST_FULL;
        else shadow_list.insert(pos - 1, val);
      end
      CMD_REMOVE_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (pos == 0 || pos > n) r.status = ST_BADPOS;
        else begin
          r.removed = shadow_list[pos - 1];
          shadow_list.delete(pos - 1);
        end
      end
      default: ;
    endcase
    r.count = 6'(shadow_list.size());
    return r;
  endfunction

  // Drives one item and waits for it to be accepted; start stays high afterward.
  task automatic send_item(logic [2:0] cmd, logic [5:0] pos, logic [31:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    position <= pos;
    value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_list_command(cmd, pos, val));
  endtask

  // Sends a directed item whose expected result is typed in.
  task automatic send_known(directed_row_t row);
    list_result_t r;
    send_item(row.cmd, row.pos, row.val);
    r = pending_results[$];
    if (row.known && (r.removed !== row.exp_removed || r.status !== row.exp_status ||
                      r.count !== row.exp_count)) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Table row disagrees with predictor: cmd %0d pos %0d", row.cmd, row.pos);
    end
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Picks a random command, mostly in range, sometimes at the edges.
  task automatic send_random_item(int push_bias);
    logic [2:0] cmd;
    logic [5:0] pos;
    logic [31:0] val;
    int n;
    int pick;
    n = shadow_list.size();
    pick = $urandom_range(99);
    if (pick < push_bias) cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    else if (pick < push_bias + 15) cmd = CMD_INSERT_AT;
    else if (pick < 80) cmd = 3'($urandom_range(2, 3));
    else if (pick < 96) cmd = CMD_REMOVE_AT;
    else cmd = 3'($urandom_range(7));
    if ($urandom_range(9) == 0) pos = 6'($urandom);
    else if (cmd == CMD_INSERT_AT) pos = 6'($urandom_range(n + 1, 1));
    else pos = 6'($urandom_range(n > 0 ? n : 1, 1));
    val = $urandom;
    send_item(cmd, pos, val);
  endtask

  // Checks each result against the oldest expectation.
  always @(posedge clk) begin
    list_result_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result at cycle %0d", cycle_count);
      end else begin
        e = pending_results.pop_front();
        result_count++;
        status_seen[status]++;
        if (removed_value !== e.removed || status !== e.status ||
            element_count !== e.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: removed %h/%h status %0d/%0d count %0d/%0d (exp/act)",
                     e.removed, removed_value, e.status, status, e.count, element_count);
        end
      end
    end
  end

  // Stops a hung run.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    directed_row_t table_rows[$];
    int idle_phases[4];
    start = 1'b0;
    command = '0;
    position = '0;
    value = '0;
    rst = 1'b1;
    mismatch_count = 0;
    result_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    idle_phases = '{0, 66, 0, 13};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: empty errors, extremes, every command and bad positions.
    table_rows = '{
      '{CMD_POP_FRONT, 6'd0, 32'h0, 1, 32'h0, ST_EMPTY, 6'd0},
      '{CMD_POP_BACK, 6'd0, 32'h0, 1, 32'h0, ST_EMPTY, 6'd0},
      '{CMD_REMOVE_AT, 6'd1, 32'h0, 1, 32'h0, ST_EMPTY, 6'd0},
      '{CMD_INSERT_AT, 6'd0, 32'h1, 1, 32'h0, ST_BADPOS, 6'd0},
      '{CMD_INSERT_AT, 6'd2, 32'h1, 1, 32'h0, ST_BADPOS, 6'd0},
      '{CMD_PUSH_BACK, 6'd0, 32'hFFFFFFFF, 1, 32'h0, ST_OK, 6'd1},
      '{CMD_PUSH_FRONT, 6'd63, 32'h00000000, 1, 32'h0, ST_OK, 6'd2},
      '{CMD_INSERT_AT, 6'd2, 32'hA5A5A5A5, 0, 0, 0, 0},
      '{CMD_INSERT_AT, 6'd4, 32'h5A5A5A5A, 0, 0, 0, 0},
      '{CMD_INSERT_AT, 6'd1, 32'h12345678, 0, 0, 0, 0},
      '{CMD_REMOVE_AT, 6'd0, 32'h0, 1, 32'h0, ST_BADPOS, 6'd5},
      '{CMD_REMOVE_AT, 6'd6, 32'h0, 1, 32'h0, ST_BADPOS, 6'd5},
      '{CMD_REMOVE_AT, 6'd63, 32'h0, 1, 32'h0, ST_BADPOS, 6'd5},
      '{CMD_REMOVE_AT, 6'd3, 32'h0, 0, 0, 0, 0},
      '{CMD_REMOVE_AT, 6'd1, 32'h0, 0, 0, 0, 0},
      '{CMD_REMOVE_AT, 6'd3, 32'h0, 0, 0, 0, 0},
      '{3'd6, 6'd1, 32'hDEADBEEF, 0, 0, 0, 0},
      '{3'd7, 6'd63, 32'hFFFFFFFF, 0, 0, 0, 0},
      '{CMD_POP_FRONT, 6'd0, 32'h0, 0, 0, 0, 0},
      '{CMD_POP_BACK, 6'd0, 32'h0, 0, 0, 0, 0}
    };
    foreach (table_rows[i]) send_known(table_rows[i]);
    // Fill to capacity, then hit the full cases.
    while (shadow_list.size() < NODES) send_item(CMD_PUSH_BACK, 6'd0, $urandom);
    send_known('{CMD_PUSH_BACK, 6'd0, 32'h1, 1, 32'h0, ST_FULL, 6'd32});
    send_known('{CMD_PUSH_FRONT, 6'd0, 32'h1, 1, 32'h0, ST_FULL, 6'd32});
    send_known('{CMD_INSERT_AT, 6'd33, 32'h1, 1, 32'h0, ST_FULL, 6'd32});
    send_known('{CMD_INSERT_AT, 6'd34, 32'h1, 1, 32'h0, ST_BADPOS, 6'd32});
    send_item(CMD_REMOVE_AT, 6'd32, 32'h0);
    send_item(CMD_REMOVE_AT, 6'd16, 32'h0);

    // Sender pauses until everything outstanding has come back.
    wait_for_results();

    // Random phases with differing idle rates and fill tendencies.
    for (int p = 0; p < 8; p++) begin
      sender_idle_pct = idle_phases[p % 4];
      repeat (RANDOM_ITEMS / 8) send_random_item((p % 2) ? 60 : 30);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results over directed and random commands in four idle phases.",
             result_count);
    $display("Status mix ok/empty/badpos/full: %0d/%0d/%0d/%0d, mismatches: %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// File: doubly_linked_list_engine.f
+incdir+sv
sv/dll_pkg.sv
sv/dll_front.sv
sv/dll_back.sv
sv/doubly_linked_list_engine.sv
sim/doubly_linked_list_engine_test.sv
